### rtl/core/dlx_pkg.sv
// Package for the longest-match lexer: sizes, codes, result type and address helpers.
`default_nettype none

package dlx_pkg;

  // table and buffer sizes
  localparam int NUM_STATES      = 256;
  localparam int NUM_SYMBOLS     = 128;
  localparam int NUM_TOKENS      = 64;
  localparam int LOOKAHEAD_DEPTH = 64;

  localparam int WINDOW   = (LOOKAHEAD_DEPTH < 64) ? LOOKAHEAD_DEPTH : 64;
  localparam int TT_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int TT_AW    = $clog2(TT_DEPTH);
  localparam int AC_AW    = $clog2(NUM_STATES);
  localparam int BUF_AW   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);

  // field widths
  localparam int OP_W    = 2;
  localparam int STATE_W = 8;
  localparam int SYM_W   = 8;
  localparam int TOK_W   = 6;
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 7;

  localparam logic [STATE_W-1:0] START_STATE = STATE_W'(1);
  localparam logic [STATE_W-1:0] DEAD_STATE  = STATE_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_WR_TRANS  = 2'd0,
    OP_WR_ACCEPT = 2'd1,
    OP_SCAN      = 2'd2,
    OP_END       = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TOKEN     = 2'd0,
    KIND_UNMATCHED = 2'd1,
    KIND_END       = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [TOK_W-1:0]  token_id;
    logic [LEN_W-1:0]  length;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUF,
    ST_TRANS,
    ST_ACC,
    ST_EMIT,
    ST_DONE,
    ST_END_PEND,
    ST_END_PUSH
  } fsm_e;

  // row * NUM_SYMBOLS + col
  function automatic logic [TT_AW-1:0] tt_addr(logic [STATE_W-1:0] row,
                                               logic [SYM_W-1:0] col);
    logic [31:0] a;
    a = 32'(row) * NUM_SYMBOLS + 32'(col);
    return a[TT_AW-1:0];
  endfunction

  // step leaves the table: dead
  function automatic logic step_oor(logic [STATE_W-1:0] st, logic [SYM_W-1:0] col);
    return (32'(st) >= NUM_STATES) || (32'(col) >= NUM_SYMBOLS);
  endfunction

  function automatic logic state_ok(logic [STATE_W-1:0] st);
    return 32'(st) < NUM_STATES;
  endfunction

  // circular buffer index, off <= WINDOW
  function automatic logic [BUF_AW-1:0] wrap_add(logic [BUF_AW-1:0] base,
                                                 logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(WINDOW)) begin
      s = s - (CNT_W + 1)'(WINDOW);
    end
    return s[BUF_AW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/dlx_in_if.sv
// Input channel: table writes, scanned characters and end of input.
`default_nettype none

interface dlx_in_if;
  import dlx_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [STATE_W-1:0] state_index;
  logic [SYM_W-1:0]   symbol;
  logic [STATE_W-1:0] next_state;
  logic [TOK_W-1:0]   token_id;

  modport source (output valid, operation, state_index, symbol, next_state, token_id,
                  input ready);
  modport sink   (input valid, operation, state_index, symbol, next_state, token_id,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/dlx_out_if.sv
// Result channel: tokens, unmatched characters and end markers.
`default_nettype none

interface dlx_out_if;
  import dlx_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TOK_W-1:0]  token_id_res;
  logic [LEN_W-1:0]  length;
  logic              last;

  modport source (output valid, kind, token_id_res, length, last, input ready);
  modport sink   (input valid, kind, token_id_res, length, last, output ready);
endinterface

`default_nettype wire

### rtl/core/dlx_cfg_if.sv
// Configuration write channel carrying the symbol base.
`default_nettype none

interface dlx_cfg_if;
  import dlx_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_base;

  modport source (output valid, symbol_base, input ready);
  modport sink   (input valid, symbol_base, output ready);
endinterface

`default_nettype wire

### rtl/core/dlx_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module dlx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/dfa_longest_match_lexer_unit.sv
// Top level of the table-driven longest-match lexer.
`default_nettype none

// Longest-match lexer driven by a loadable DFA. Write words load the transition
// table (row = state, column = symbol) and the accept table (state -> token id,
// 0 = not accepting). Scan words step the DFA from state 1 over the buffered
// lookahead and remember the last accepting prefix. When a step dies, or the
// lookahead window fills, the longest prefix is emitted as a token (or one
// character as unmatched) and the rest of the buffer is replayed from state 1.
// End of input flushes the buffer and closes with an end result; the final
// result of each input word carries last = 1.
// Flow: a scanned character that keeps the match alive passes the transition RAM
// read, then the accept RAM read on the new state; no new word is taken until
// it is through. Each result passes an emit step, and each replayed character a
// lookahead RAM read, a transition read and an accept read. Results wait in an
// output register, so a new word is taken while the last result is still held.
// After reset the block runs a clearing pass over all NUM_STATES * NUM_SYMBOLS
// transition table entries (32768 by default), one entry a cycle; the accept
// table is cleared in the same pass. No input word is taken during that pass;
// configuration writes are. Write symbol_base only while the lexer is idle.

module dfa_longest_match_lexer_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  dlx_in_if.sink   in_i,
  dlx_cfg_if.sink  cfg_i,
  dlx_out_if.source res_o
);
  import dlx_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fsm_e               fsm_q, fsm_d;
  logic [TT_AW-1:0]   clr_q, clr_d;
  logic [SYM_W-1:0]   base_q, base_d;
  logic [STATE_W-1:0] st_q, st_d;        // DFA state after buffer[0..pos)
  logic [TOK_W-1:0]   bt_q, bt_d;        // best token so far
  logic [CNT_W-1:0]   bl_q, bl_d;        // best length so far
  logic [CNT_W-1:0]   cnt_q, cnt_d;      // lookahead fill
  logic [BUF_AW-1:0]  head_q, head_d;    // oldest lookahead character
  logic [CNT_W-1:0]   pos_q, pos_d;      // index of character being stepped
  logic               at_end_q, at_end_d;
  logic               pend_valid_q, pend_valid_d;
  logic               out_valid_q;

  // payload registers
  logic [STATE_W-1:0] nx_q, nx_d;
  logic               nx_ok_q, nx_ok_d;
  res_t               pend_q, pend_d;    // held back until we know if it is last
  res_t               out_q;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic               tt_we, tt_re;
  logic [TT_AW-1:0]   tt_waddr, tt_raddr;
  logic [STATE_W-1:0] tt_wdata, tt_rdata;

  logic               ac_we, ac_re;
  logic [AC_AW-1:0]   ac_waddr, ac_raddr;
  logic [TOK_W-1:0]   ac_wdata, ac_rdata;

  logic               lb_we, lb_re;
  logic [BUF_AW-1:0]  lb_waddr, lb_raddr;
  logic [SYM_W-1:0]   lb_wdata, lb_rdata;

  dlx_ram #(.WIDTH(STATE_W), .DEPTH(TT_DEPTH)) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (tt_we),
    .waddr_i (tt_waddr),
    .wdata_i (tt_wdata),
    .re_i    (tt_re),
    .raddr_i (tt_raddr),
    .rdata_o (tt_rdata)
  );

  dlx_ram #(.WIDTH(TOK_W), .DEPTH(NUM_STATES)) u_accept_ram (
    .clk_i   (clk_i),
    .we_i    (ac_we),
    .waddr_i (ac_waddr),
    .wdata_i (ac_wdata),
    .re_i    (ac_re),
    .raddr_i (ac_raddr),
    .rdata_o (ac_rdata)
  );

  dlx_ram #(.WIDTH(SYM_W), .DEPTH(WINDOW)) u_lookahead_ram (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (lb_wdata),
    .re_i    (lb_re),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared step datapath: character comes from the port in idle, else from
  // the lookahead RAM during replay.
  // ---------------------------------------------------------------------------
  logic [SYM_W-1:0] step_ch, step_col;
  logic             step_dead;
  logic [TT_AW-1:0] step_addr;

  assign step_ch   = (fsm_q == ST_IDLE) ? in_i.symbol : lb_rdata;
  assign step_col  = step_ch - base_q;
  assign step_dead = step_oor(st_q, step_col);
  assign step_addr = tt_addr(st_q, step_col);

  // emitted result for the current best prefix
  res_t             emit_res;
  logic [CNT_W-1:0] drop;
  logic [CNT_W-1:0] cnt_left;
  logic [BUF_AW-1:0] head_next;

  always_comb begin
    if (bl_q != '0) begin
      emit_res.kind     = KIND_TOKEN;
      emit_res.token_id = bt_q;
      emit_res.length   = LEN_W'(bl_q);
      drop              = bl_q;
    end else begin
      emit_res.kind     = KIND_UNMATCHED;
      emit_res.token_id = '0;
      emit_res.length   = LEN_W'(1);
      drop              = CNT_W'(1);
    end
    emit_res.last = 1'b0;
  end

  assign cnt_left  = cnt_q - drop;
  assign head_next = wrap_add(head_q, drop);

  logic [CNT_W-1:0] pos_inc;
  logic [TOK_W-1:0] acc_tok;

  assign pos_inc = pos_q + CNT_W'(1);
  assign acc_tok = nx_ok_q ? ac_rdata : '0;

  // where to go once the whole buffer has been stepped without dying
  function automatic fsm_e finish_next(logic at_end, logic [CNT_W-1:0] cnt, logic pend);
    if (at_end) begin
      return (cnt != '0) ? ST_EMIT : ST_END_PEND;
    end else if (cnt == CNT_W'(WINDOW)) begin
      return ST_EMIT;          // window full: cut the scan
    end else begin
      return pend ? ST_DONE : ST_IDLE;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic out_free;
  logic push;
  res_t push_res;

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    fsm_d        = fsm_q;
    clr_d        = clr_q;
    st_d         = st_q;
    bt_d         = bt_q;
    bl_d         = bl_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    pos_d        = pos_q;
    at_end_d     = at_end_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    nx_d         = nx_q;
    nx_ok_d      = nx_ok_q;

    push     = 1'b0;
    push_res = pend_q;

    in_i.ready = 1'b0;

    tt_we    = 1'b0;
    tt_waddr = step_addr;
    tt_wdata = in_i.next_state;
    tt_re    = 1'b0;
    tt_raddr = step_addr;

    ac_we    = 1'b0;
    ac_waddr = AC_AW'(in_i.state_index);
    ac_wdata = '0;
    ac_re    = 1'b0;
    ac_raddr = AC_AW'(tt_rdata);

    lb_we    = 1'b0;
    lb_waddr = wrap_add(head_q, cnt_q);
    lb_wdata = in_i.symbol;
    lb_re    = 1'b0;
    lb_raddr = wrap_add(head_q, pos_inc);

    case (fsm_q)
      ST_CLEAR: begin
        tt_we    = 1'b1;
        tt_waddr = clr_q;
        tt_wdata = DEAD_STATE;
        ac_we    = 32'(clr_q) < NUM_STATES;
        ac_waddr = AC_AW'(clr_q);
        clr_d    = clr_q + TT_AW'(1);
        if (clr_q == TT_AW'(TT_DEPTH - 1)) begin
          fsm_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          case (op_e'(in_i.operation))
            OP_WR_TRANS: begin
              tt_we    = state_ok(in_i.state_index) && (32'(in_i.symbol) < NUM_SYMBOLS);
              tt_waddr = tt_addr(in_i.state_index, in_i.symbol);
            end
            OP_WR_ACCEPT: begin
              ac_we    = state_ok(in_i.state_index);
              ac_wdata = (32'(in_i.token_id) < NUM_TOKENS) ? in_i.token_id : '0;
            end
            OP_SCAN: begin
              lb_we    = 1'b1;
              cnt_d    = cnt_q + CNT_W'(1);
              pos_d    = cnt_q;
              at_end_d = 1'b0;
              if (step_dead) begin
                fsm_d = ST_EMIT;
              end else begin
                tt_re = 1'b1;
                fsm_d = ST_TRANS;
              end
            end
            OP_END: begin
              // buffer is alive here, so bt/bl already hold its best prefix
              at_end_d = 1'b1;
              fsm_d    = (cnt_q != '0) ? ST_EMIT : ST_END_PEND;
            end
            default: begin
            end
          endcase
        end
      end

      ST_BUF: begin
        if (step_dead) begin
          fsm_d = ST_EMIT;
        end else begin
          tt_re = 1'b1;
          fsm_d = ST_TRANS;
        end
      end

      ST_TRANS: begin
        if (tt_rdata == DEAD_STATE) begin
          fsm_d = ST_EMIT;
        end else begin
          nx_d    = tt_rdata;
          nx_ok_d = state_ok(tt_rdata);
          ac_re   = state_ok(tt_rdata);
          fsm_d   = ST_ACC;
        end
      end

      ST_ACC: begin
        st_d  = nx_q;
        pos_d = pos_inc;
        if (acc_tok != '0) begin
          bt_d = acc_tok;
          bl_d = pos_inc;
        end
        if (pos_inc == cnt_q) begin
          fsm_d = finish_next(at_end_q, cnt_q, pend_valid_q);
        end else begin
          lb_re = 1'b1;
          fsm_d = ST_BUF;
        end
      end

      ST_EMIT: begin
        if (!pend_valid_q || out_free) begin
          push         = pend_valid_q;     // an earlier result, not the last one
          pend_d       = emit_res;
          pend_valid_d = 1'b1;
          head_d       = head_next;
          cnt_d        = cnt_left;
          st_d         = START_STATE;
          bt_d         = '0;
          bl_d         = '0;
          pos_d        = '0;
          if (cnt_left == '0) begin
            fsm_d = finish_next(at_end_q, cnt_left, 1'b1);
          end else begin
            lb_re    = 1'b1;
            lb_raddr = head_next;
            fsm_d    = ST_BUF;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          push          = 1'b1;
          push_res.last = 1'b1;
          pend_valid_d  = 1'b0;
          fsm_d         = ST_IDLE;
        end
      end

      ST_END_PEND: begin
        if (!pend_valid_q) begin
          fsm_d = ST_END_PUSH;
        end else if (out_free) begin
          push         = 1'b1;
          pend_valid_d = 1'b0;
          fsm_d        = ST_END_PUSH;
        end
      end

      ST_END_PUSH: begin
        if (out_free) begin
          push              = 1'b1;
          push_res.kind     = KIND_END;
          push_res.token_id = '0;
          push_res.length   = '0;
          push_res.last     = 1'b1;
          st_d              = START_STATE;
          bt_d              = '0;
          bl_d              = '0;
          at_end_d          = 1'b0;
          fsm_d             = ST_IDLE;
        end
      end

      default: begin
        fsm_d = ST_IDLE;
      end
    endcase
  end

  // configuration register
  assign cfg_i.ready = 1'b1;
  assign base_d      = cfg_i.valid ? cfg_i.symbol_base : base_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q        <= ST_CLEAR;
      clr_q        <= '0;
      base_q       <= '0;
      st_q         <= START_STATE;
      bt_q         <= '0;
      bl_q         <= '0;
      cnt_q        <= '0;
      head_q       <= '0;
      pos_q        <= '0;
      at_end_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fsm_q        <= fsm_d;
      clr_q        <= clr_d;
      base_q       <= base_d;
      st_q         <= st_d;
      bt_q         <= bt_d;
      bl_q         <= bl_d;
      cnt_q        <= cnt_d;
      head_q       <= head_d;
      pos_q        <= pos_d;
      at_end_q     <= at_end_d;
      pend_valid_q <= pend_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q    <= nx_d;
    nx_ok_q <= nx_ok_d;
    pend_q  <= pend_d;
    if (push) begin
      out_q <= push_res;
    end
  end

  // output word
  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.token_id_res = out_q.token_id;
  assign res_o.length       = out_q.length;
  assign res_o.last         = out_q.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || res_o.ready))
    else $error("result register overwritten while full");

  // the held-back result is always flushed before new words are taken
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending result left behind in idle");

  // end of input leaves an empty buffer and a restarted scan
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_END_PUSH && out_free) |=>
      (fsm_q == ST_IDLE && st_q == START_STATE && cnt_q == '0 && bl_q == '0))
    else $error("scan not restarted after end of input");

  // step position stays inside the filled part of the window
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= cnt_q) && (cnt_q <= CNT_W'(WINDOW)))
    else $error("lookahead position or fill out of range");

endmodule

`default_nettype wire
